>>> src/top_k_min_heap_selector_top_assert.svh
// assertion macros for the top-k heap selector
// included by the modules that carry concurrent assertions
`ifndef TOP_K_MIN_HEAP_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_MIN_HEAP_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication under the active-low reset
`define TKH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tkh assertion failed");

// next-cycle implication under the active-low reset
`define TKH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tkh assertion failed");

`endif

>>> src/tkh_pkg.sv
// shared types, field widths and command codes of the top-k heap selector
// no dependencies
`default_nettype none

package tkh_pkg;

  localparam int ID_W         = 31;
  localparam int SCORE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int K_W          = 5;
  localparam int DATA_W       = 64;
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_DUMP     = 16;

  localparam logic [K_W-1:0] K_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER = 2'd0,
    CMD_DUMP  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  // signed order on the raw score bits
  function automatic logic score_gt(input logic [SCORE_W-1:0] a,
                                    input logic [SCORE_W-1:0] b);
    score_gt = $signed(a) > $signed(b);
  endfunction

endpackage

`default_nettype wire

>>> src/top_k_min_heap_selector_top.sv
// Top-k selector: min-heap by score held in one two-read-port synchronous memory.
// Offer: written at once when empty; when full, S_RCHK drops a score not above the root.
//   Sift up: S_UP per level, S_PUT at the root. Root replace: S_DOWN per level after
//   S_RCHK (none with one entry held), S_PUT at a leaf. One memory read-compare per level.
// Dump: entries go out in index order, one word per cycle while taken;
//   no input is taken until a command finishes. Reset clears count, valid, active_k=16.
`default_nettype none

module top_k_min_heap_selector_top #(
  parameter int CAPACITY = tkh_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration: active_k
  input  wire logic                      cfg_we_i,
  input  wire logic [tkh_pkg::K_W-1:0]   cfg_wdata_i,
  // input stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [tkh_pkg::DATA_W-1:0] s_axis_tdata,  // cand_id[30:0], cand_score[62:31], pad
  input  wire logic [tkh_pkg::CMD_W-1:0] s_axis_tuser,   // command[1:0]
  // output stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [tkh_pkg::DATA_W-1:0]     m_axis_tdata,   // out_id[30:0], out_score[62:31], pad
  output logic                           m_axis_tuser,   // entry_valid
  output logic                           m_axis_tlast    // is_last
);

  import tkh_pkg::*;

  `include "top_k_min_heap_selector_top_assert.svh"

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HCW = $clog2(CAPACITY + 1);
  localparam int KW  = (HCW > K_W) ? HCW : K_W;
  localparam int DW  = IW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_RCHK  = 3'd2;
  localparam logic [2:0] S_DOWN  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_DUMP  = 3'd5;
  localparam logic [2:0] S_EMPTY = 3'd6;

  // control and working registers
  logic [2:0]     state_q, state_d;
  logic [HCW-1:0] held_q, held_d;
  logic [K_W-1:0] k_q;
  entry_t         cand_q, cand_d;
  logic [IW-1:0]  hole_q, hole_d;
  logic [DW-1:0]  child_q, child_d;

  // output register
  logic   out_valid_q, out_valid_d;
  entry_t out_ent_q, out_ent_d;
  logic   out_flag_q, out_flag_d;
  logic   out_last_q, out_last_d;
  logic   out_free;

  // entry memory
  entry_t        heap_mem_q [CAPACITY];
  entry_t        rda_q, rdb_q;
  logic          rd_en;
  logic [IW-1:0] ra_addr, rb_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  // derived quantities
  logic [KW-1:0]  keff;
  logic [KW-1:0]  held_k;
  logic [HCW-1:0] last_h;
  logic [DW-1:0]  last_d;
  logic [KW-1:0]  dump_n;
  logic           dump_end;
  logic           s_fire;
  entry_t         in_ent;
  cmd_e           cmd;

  // down-step helpers
  logic           sel_right;
  logic [DW-1:0]  c_idx;
  entry_t         c_ent;
  logic [DW-1:0]  next_child;
  logic [IW-1:0]  parent_idx;
  logic [IW-1:0]  gparent_idx;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_ent   = '{score: s_axis_tdata[ID_W +: SCORE_W], id: s_axis_tdata[ID_W-1:0]};
  assign cmd      = cmd_e'(s_axis_tuser);

  // effective k: zero acts as one, above capacity acts as capacity
  always_comb begin
    if (k_q == '0) begin
      keff = KW'(1);
    end else if (KW'(k_q) > KW'(CAPACITY)) begin
      keff = KW'(CAPACITY);
    end else begin
      keff = KW'(k_q);
    end
  end

  assign held_k   = KW'(held_q);
  assign last_h   = held_q - HCW'(1);
  assign last_d   = DW'(last_h);
  assign dump_n   = (held_k > KW'(MAX_DUMP)) ? KW'(MAX_DUMP) : held_k;
  assign dump_end = (KW'(hole_q) + KW'(1)) == dump_n;

  assign parent_idx  = (hole_q - IW'(1)) >> 1;
  assign gparent_idx = (parent_idx - IW'(1)) >> 1;

  // pick the smaller child, left on a tie
  assign sel_right  = (child_q < last_d) && score_gt(rda_q.score, rdb_q.score);
  assign c_idx      = sel_right ? child_q + DW'(1) : child_q;
  assign c_ent      = sel_right ? rdb_q : rda_q;
  assign next_child = {c_idx[IW-1:0], 1'b1};

  // sequencer
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    cand_d      = cand_q;
    hole_d      = hole_q;
    child_d     = child_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ent_d   = out_ent_q;
    out_flag_d  = out_flag_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    ra_addr     = '0;
    rb_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = hole_q;
    mem_wdata   = cand_q;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cand_d = in_ent;
          case (cmd)
            CMD_OFFER: begin
              if (held_k < keff) begin
                held_d = held_q + HCW'(1);
                if (held_q == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = in_ent;
                end else begin
                  hole_d  = IW'(held_q);
                  rd_en   = 1'b1;
                  ra_addr = IW'((held_q - HCW'(1)) >> 1);
                  rb_addr = ra_addr;
                  state_d = S_UP;
                end
              end else if (held_q != '0) begin
                rd_en   = 1'b1;
                state_d = S_RCHK;
              end
            end
            CMD_DUMP: begin
              hole_d = '0;
              if (held_q == '0) begin
                state_d = S_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_DUMP;
              end
            end
            CMD_CLEAR: begin
              held_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // rda holds the parent of the hole
      S_UP: begin
        mem_we = 1'b1;
        if (score_gt(rda_q.score, cand_q.score)) begin
          mem_wdata = rda_q;
          hole_d    = parent_idx;
          if (parent_idx == '0) begin
            state_d = S_PUT;
          end else begin
            rd_en   = 1'b1;
            ra_addr = gparent_idx;
            rb_addr = gparent_idx;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      // rda holds the root
      S_RCHK: begin
        if (score_gt(cand_q.score, rda_q.score)) begin
          hole_d = '0;
          if (held_q > HCW'(1)) begin
            rd_en   = 1'b1;
            ra_addr = IW'(1);
            rb_addr = (held_q > HCW'(2)) ? IW'(2) : IW'(1);
            child_d = DW'(1);
            state_d = S_DOWN;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      // rda/rdb hold the children of the hole
      S_DOWN: begin
        mem_we = 1'b1;
        if (!score_gt(cand_q.score, c_ent.score)) begin
          state_d = S_IDLE;
        end else begin
          mem_wdata = c_ent;
          hole_d    = c_idx[IW-1:0];
          if (next_child <= last_d) begin
            rd_en   = 1'b1;
            ra_addr = next_child[IW-1:0];
            rb_addr = (next_child < last_d) ? IW'(next_child + DW'(1)) : next_child[IW-1:0];
            child_d = next_child;
          end else begin
            state_d = S_PUT;
          end
        end
      end

      S_PUT: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end

      // rda holds entry hole_q of the dump
      S_DUMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ent_d   = rda_q;
          out_flag_d  = 1'b1;
          out_last_d  = dump_end;
          if (dump_end) begin
            state_d = S_IDLE;
          end else begin
            hole_d  = hole_q + IW'(1);
            rd_en   = 1'b1;
            ra_addr = hole_q + IW'(1);
            rb_addr = ra_addr;
          end
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ent_d   = '0;
          out_flag_d  = 1'b0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      k_q         <= K_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    hole_q     <= hole_d;
    child_q    <= child_d;
    out_ent_q  <= out_ent_d;
    out_flag_q <= out_flag_d;
    out_last_q <= out_last_d;
  end

  // entry memory, one write and two registered reads per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rda_q <= heap_mem_q[ra_addr];
      rdb_q <= heap_mem_q[rb_addr];
    end
  end

  // output port
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_ent_q.score, out_ent_q.id};
  assign m_axis_tuser  = out_flag_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  `TKH_ASSERT_IMPL(a_no_rw_same_addr, clk_i, rst_ni, mem_we && rd_en,
    (mem_waddr != ra_addr) && (mem_waddr != rb_addr))
  `TKH_ASSERT_IMPL(a_held_in_range, clk_i, rst_ni, 1'b1, KW'(held_q) <= KW'(CAPACITY))
  `TKH_ASSERT_NEXT(a_dump_last_ends, clk_i, rst_ni,
    (state_q == S_DUMP) && out_free && dump_end, state_q == S_IDLE)
  `TKH_ASSERT_NEXT(a_held_step, clk_i, rst_ni, state_q != S_IDLE,
    held_q == $past(held_q))

endmodule

`default_nettype wire

>>> tb/top_k_min_heap_selector_top_tb.sv
// Self-checking testbench for the top-k min-heap selector: offers, dumps, clears and
// the unused command are streamed in, and each dumped word is checked against a heap kept here.
// Depends on tkh_pkg and top_k_min_heap_selector_top.
`timescale 1ns / 1ps

module top_k_min_heap_selector_top_tb;
  import tkh_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } cand_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic                      valid;
    logic                      last;
  } dump_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [K_W-1:0]      cfg_wdata_i = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                sink_ready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  // stimulus, expectations and heap copy
  cand_t               cand_q[$];
  cand_t               cur_cand;
  dump_word_t          dump_q[$];
  logic [ID_W-1:0]     heap_id [CAPACITY_DEF];
  logic signed [SCORE_W-1:0] heap_sc [CAPACITY_DEF];
  int                  held_n = 0;
  logic [K_W-1:0]      kept_k = K_RESET;

  int idle_pct = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;

  top_k_min_heap_selector_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (sink_ready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // apply one accepted command to the local heap and queue the words it dumps
  function automatic void update_heap(input cand_t c);
    int lim;
    int pos;
    int par;
    int hole;
    int child;
    int last_idx;
    logic [ID_W-1:0] tid;
    logic signed [SCORE_W-1:0] tsc;
    dump_word_t w;
    lim = (kept_k == 0) ? 1 : ((kept_k > CAPACITY_DEF) ? CAPACITY_DEF : int'(kept_k));
    case (c.cmd)
      CMD_OFFER: begin
        if (held_n < lim && held_n < CAPACITY_DEF) begin
          // append and sift up
          heap_id[held_n] = c.id;
          heap_sc[held_n] = c.score;
          pos = held_n;
          held_n++;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if ($signed(heap_sc[par]) > $signed(heap_sc[pos])) begin
              tid = heap_id[par];
              tsc = heap_sc[par];
              heap_id[par] = heap_id[pos];
              heap_sc[par] = heap_sc[pos];
              heap_id[pos] = tid;
              heap_sc[pos] = tsc;
            end
            pos = par;
          end
        end else if (held_n > 0 && $signed(c.score) > $signed(heap_sc[0])) begin
          // replace the root and sift down, left child wins ties
          last_idx = held_n - 1;
          hole = 0;
          child = 1;
          while (child <= last_idx) begin
            if (child < last_idx && $signed(heap_sc[child]) > $signed(heap_sc[child + 1]))
              child++;
            if ($signed(c.score) <= $signed(heap_sc[child]))
              break;
            heap_id[hole] = heap_id[child];
            heap_sc[hole] = heap_sc[child];
            hole = child;
            child = 2 * hole + 1;
          end
          heap_id[hole] = c.id;
          heap_sc[hole] = c.score;
        end
      end
      CMD_DUMP: begin
        if (held_n == 0) begin
          w = '{id: '0, score: '0, valid: 1'b0, last: 1'b1};
          dump_q.insert(dump_q.size(), w);
        end else begin
          for (int i = 0; i < held_n && i < MAX_DUMP; i++) begin
            w.id    = heap_id[i];
            w.score = heap_sc[i];
            w.valid = 1'b1;
            w.last  = (i + 1 == held_n) || (i + 1 == MAX_DUMP);
            dump_q.insert(dump_q.size(), w);
          end
        end
      end
      CMD_CLEAR: held_n = 0;
      default: ;
    endcase
  endfunction

  // source side: present queued words, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        update_heap(cur_cand);
        words_in++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the word until taken
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (cand_q.size() != 0) begin
        cur_cand = cand_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cur_cand.score, cur_cand.id};
        s_tuser  <= cur_cand.cmd;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          src_gap = $urandom_range(1, 15);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side: check each dumped word, random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    dump_word_t want;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      if (m_tvalid && sink_ready) begin
        words_out++;
        if (dump_q.size() == 0) begin
          $error("unexpected output word: id %h score %h", m_tdata[30:0], m_tdata[62:31]);
          errors++;
        end else begin
          want = dump_q.pop_front();
          if (m_tdata[30:0] !== want.id) begin
            $error("out_id mismatch: expected %h, got %h", want.id, m_tdata[30:0]);
            errors++;
          end
          if (m_tdata[62:31] !== want.score) begin
            $error("out_score mismatch: expected %h, got %h", want.score, m_tdata[62:31]);
            errors++;
          end
          if (m_tuser !== want.valid) begin
            $error("entry_valid mismatch: expected %b, got %b", want.valid, m_tuser);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("is_last mismatch: expected %b, got %b", want.last, m_tlast);
            errors++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          sink_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic push_cand(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] score);
    cand_t c;
    c.cmd   = cmd;
    c.id    = id;
    c.score = score;
    cand_q.insert(cand_q.size(), c);
  endtask

  // wait for every word taken and every dump word seen, then let the block settle
  task automatic drain;
    @(negedge clk_i);
    while (cand_q.size() != 0 || s_tvalid || dump_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [K_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    kept_k = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [K_W-1:0] k_list [5];
    int pct_list [5];
    logic [31:0] rnd;
    logic signed [SCORE_W-1:0] sc;
    int r;
    k_list   = '{5'd31, 5'd3, 5'd1, 5'd8, 5'd0};
    pct_list = '{30, 0, 50, 20, 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default k: empty dump, unused code, field extremes, equal scores, clear
    idle_pct = 25;
    push_cand(CMD_DUMP, '0, '0);
    push_cand(CMD_UNUSED, 31'h7FFFFFFF, 32'sh7FFFFFFF);
    push_cand(CMD_OFFER, 31'h7FFFFFFF, 32'sh80000000);
    push_cand(CMD_OFFER, 31'h0, 32'sh7FFFFFFF);
    push_cand(CMD_OFFER, 31'd5, 32'sh0);
    push_cand(CMD_OFFER, 31'd6, -32'sd1);
    push_cand(CMD_OFFER, 31'd7, 32'sh0);
    push_cand(CMD_DUMP, '0, '0);
    push_cand(CMD_CLEAR, '0, '0);
    push_cand(CMD_DUMP, '0, '0);
    drain();

    // k of two: ties and lower scores dropped, higher replaces root
    write_k(5'd2);
    push_cand(CMD_OFFER, 31'd1, 32'sd100);
    push_cand(CMD_OFFER, 31'd2, 32'sd100);
    push_cand(CMD_OFFER, 31'd3, 32'sd100);
    push_cand(CMD_OFFER, 31'd4, 32'sd50);
    push_cand(CMD_OFFER, 31'd5, 32'sd200);
    push_cand(CMD_DUMP, '0, '0);
    drain();

    // k of zero acts as one while two are held: root replaced over both entries
    write_k(5'd0);
    push_cand(CMD_OFFER, 31'd6, 32'sd300);
    push_cand(CMD_OFFER, 31'd7, 32'sd10);
    push_cand(CMD_DUMP, '0, '0);
    drain();

    // random phases, one k setting each, the last without idling
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        rnd = $urandom();
        k_list[p] = rnd[K_W-1:0];
      end
      write_k(k_list[p]);
      idle_pct = pct_list[p];
      for (int n = 0; n < 18; n++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: sc = $urandom();
          1: sc = $urandom_range(0, 8) - 4;
          2: sc = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
          default: sc = {1'b0, 31'($urandom())};
        endcase
        rnd = $urandom();
        if (r < 78)
          push_cand(CMD_OFFER, rnd[ID_W-1:0], sc);
        else if (r < 90)
          push_cand(CMD_DUMP, rnd[ID_W-1:0], sc);
        else if (r < 96)
          push_cand(CMD_CLEAR, rnd[ID_W-1:0], sc);
        else
          push_cand(CMD_UNUSED, rnd[ID_W-1:0], sc);
      end
      push_cand(CMD_DUMP, '0, '0);
      drain();
    end

    $display("covered %0d commands in and %0d dump words out", words_in, words_out);
    $display("k settings 0, 1, 2, 3, 8, 16, 31 and one random, with and without stalls");
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
